@@ design/nested_word_tree_tokenizer_top_assert.svh @@
// Assertion macros for the tokenizer. Each macro places one concurrent
// assertion that is clocked on the rising edge and disabled during reset.
`ifndef NESTED_WORD_TREE_TOKENIZER_TOP_ASSERT_SVH
`define NESTED_WORD_TREE_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define NWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// Next-cycle implication.
`define NWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define NWT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/nwt_pkg.sv @@
// ----------------------------------------------------------------------------
// nwt_pkg
// Shared types, codes and constants of the nested word tree tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nwt_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int LEVEL_BITS_DEF   = 4;

    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ESCAPE  = 8'h5C;

    localparam logic CFG_MAX_TREE = 1'b0;
    localparam logic CFG_MAX_LIT  = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BEGIN = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_READ  = 2'd3
    } nwt_mode_t;

    typedef enum logic [2:0] {
        STAT_ACCEPTED = 3'd0,
        STAT_TOKEN    = 3'd1,
        STAT_END      = 3'd2,
        STAT_CLOSE    = 3'd3,
        STAT_UNCLOSED = 3'd4
    } nwt_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BEGIN,
        S_READ,
        S_READ_WAIT,
        S_NEXT,
        S_SK_RD,
        S_SK_EV,
        S_TR_RD,
        S_TR_EV,
        S_LT_RD,
        S_LT_EV,
        S_CP_RD,
        S_CP_EV,
        S_EMIT
    } nwt_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_in;
        logic [9:0]  position;
        logic [10:0] text_length;
    } nwt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  token_level;
        logic [9:0]  token_start;
        logic [10:0] token_length;
        logic [10:0] unescaped_length;
        logic [7:0]  read_byte;
    } nwt_out_t;

    typedef struct packed {
        logic [3:0] max_tree_depth;
        logic [3:0] max_literal_depth;
    } nwt_cfg_t;

    function automatic logic spacey(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NEWLINE);
    endfunction

endpackage

`default_nettype wire

@@ design/nwt_if.sv @@
// ----------------------------------------------------------------------------
// nwt_in_if / nwt_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface nwt_in_if;
    logic             valid;
    logic             ready;
    nwt_pkg::nwt_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nwt_out_if;
    logic              valid;
    logic              ready;
    nwt_pkg::nwt_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/nwt_ram.sv @@
// ----------------------------------------------------------------------------
// nwt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/nwt_seq.sv @@
// ----------------------------------------------------------------------------
// nwt_seq
// Request sequencer: drives the text buffer and walks tokens byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nested_word_tree_tokenizer_top_assert.svh"

module nwt_seq #(
    parameter int BUFFER_BYTES = nwt_pkg::BUFFER_BYTES_DEF,
    parameter int LEVEL_BITS   = nwt_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire nwt_pkg::nwt_cfg_t               cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire nwt_pkg::nwt_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output nwt_pkg::nwt_out_t                    out_data,
    output logic                                 ram_we,
    output logic [$clog2(BUFFER_BYTES)-1:0]      ram_waddr,
    output logic [7:0]                           ram_wdata,
    output logic [$clog2(BUFFER_BYTES)-1:0]      ram_raddr,
    input  wire logic [7:0]                      ram_rdata
);

    localparam int AW        = $clog2(BUFFER_BYTES);
    localparam int LW        = AW + 1;
    localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;

    nwt_pkg::nwt_state_t state_reg, state_next;
    nwt_pkg::nwt_in_t    req_reg, req_next;
    nwt_pkg::nwt_out_t   res_reg, res_next;
    nwt_pkg::nwt_out_t   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [LEVEL_BITS-1:0] lvl_reg, lvl_next;
    logic                fin_reg, fin_next;
    logic [LW-1:0]       s_reg, s_next;
    logic [LW-1:0]       rem_reg, rem_next;
    logic [LW-1:0]       i_reg, i_next;
    logic [LW-1:0]       j_reg, j_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [LW-1:0]       depth_reg, depth_next;
    logic                sp0_reg, sp0_next;
    logic                split_reg, split_next;
    logic                esc_reg, esc_next;

    logic                accept;
    logic                emit_go;
    logic                in_range;
    logic [7:0]          c;
    logic [LW-1:0]       dnew;

    assign accept   = in_valid && in_ready;
    assign emit_go  = (state_reg == nwt_pkg::S_EMIT) && (!out_valid_reg || out_ready);
    assign in_range = 32'(req_reg.position) < BUFFER_BYTES;
    assign c        = ram_rdata;
    assign in_ready = (state_reg == nwt_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (c == nwt_pkg::CH_OPEN)
        begin
            dnew = depth_reg + LW'(1);
        end
        else if (c == nwt_pkg::CH_CLOSE)
        begin
            dnew = depth_reg - LW'(1);
        end
        else
        begin
            dnew = depth_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nwt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.mode)
                        nwt_pkg::MODE_LOAD:  state_next = nwt_pkg::S_LOAD;
                        nwt_pkg::MODE_BEGIN: state_next = nwt_pkg::S_BEGIN;
                        nwt_pkg::MODE_NEXT:  state_next = nwt_pkg::S_NEXT;
                        default:             state_next = nwt_pkg::S_READ;
                    endcase
                end
            end
            nwt_pkg::S_LOAD:      state_next = nwt_pkg::S_EMIT;
            nwt_pkg::S_BEGIN:     state_next = nwt_pkg::S_EMIT;
            nwt_pkg::S_READ:      state_next = nwt_pkg::S_READ_WAIT;
            nwt_pkg::S_READ_WAIT: state_next = nwt_pkg::S_EMIT;
            nwt_pkg::S_NEXT:
            begin
                state_next = fin_reg ? nwt_pkg::S_EMIT : nwt_pkg::S_SK_RD;
            end
            nwt_pkg::S_SK_RD:
            begin
                state_next = (pos_reg >= len_reg) ? nwt_pkg::S_EMIT : nwt_pkg::S_SK_EV;
            end
            nwt_pkg::S_SK_EV:
            begin
                if (c == nwt_pkg::CH_CLOSE)
                begin
                    state_next = (lvl_reg != '0) ? nwt_pkg::S_SK_RD : nwt_pkg::S_EMIT;
                end
                else if (c == nwt_pkg::CH_OPEN)
                begin
                    state_next = nwt_pkg::S_TR_RD;
                end
                else
                begin
                    state_next = nwt_pkg::S_LT_RD;
                end
            end
            nwt_pkg::S_TR_RD:
            begin
                state_next = (i_reg >= rem_reg) ? nwt_pkg::S_EMIT : nwt_pkg::S_TR_EV;
            end
            nwt_pkg::S_TR_EV:
            begin
                state_next = (dnew == '0) ? nwt_pkg::S_EMIT : nwt_pkg::S_TR_RD;
            end
            nwt_pkg::S_LT_RD:
            begin
                state_next = (i_reg >= rem_reg) ? nwt_pkg::S_CP_RD : nwt_pkg::S_LT_EV;
            end
            nwt_pkg::S_LT_EV:
            begin
                if (!sp0_reg && (c == nwt_pkg::CH_ESCAPE))
                begin
                    state_next = nwt_pkg::S_LT_RD;
                end
                else if ((split_reg && (sp0_reg != nwt_pkg::spacey(c)))
                         || (c == nwt_pkg::CH_OPEN) || (c == nwt_pkg::CH_CLOSE))
                begin
                    state_next = nwt_pkg::S_CP_RD;
                end
                else
                begin
                    state_next = nwt_pkg::S_LT_RD;
                end
            end
            nwt_pkg::S_CP_RD: state_next = nwt_pkg::S_CP_EV;
            nwt_pkg::S_CP_EV:
            begin
                if (!esc_reg && (c == nwt_pkg::CH_ESCAPE) && ((i_reg + LW'(1)) < n_reg))
                begin
                    state_next = nwt_pkg::S_CP_RD;
                end
                else
                begin
                    state_next = ((i_reg + LW'(1)) < n_reg) ? nwt_pkg::S_CP_RD
                                                             : nwt_pkg::S_EMIT;
                end
            end
            nwt_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = nwt_pkg::S_IDLE;
                end
            end
            default: state_next = nwt_pkg::S_IDLE;
        endcase
    end

    // Datapath and buffer control.
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        lvl_next       = lvl_reg;
        fin_next       = fin_reg;
        s_next         = s_reg;
        rem_next       = rem_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        depth_next     = depth_reg;
        sp0_next       = sp0_reg;
        split_next     = split_reg;
        esc_next       = esc_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(req_reg.position);
        ram_wdata      = req_reg.byte_in;
        ram_raddr      = AW'(s_reg + i_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nwt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_data;
                    res_next = '0;
                end
            end
            nwt_pkg::S_LOAD:
            begin
                ram_we = in_range;
            end
            nwt_pkg::S_BEGIN:
            begin
                len_next = (32'(req_reg.text_length) > BUFFER_BYTES)
                           ? LW'(BUFFER_BYTES) : LW'(req_reg.text_length);
                pos_next = '0;
                lvl_next = '0;
                fin_next = 1'b0;
            end
            nwt_pkg::S_READ:
            begin
                ram_raddr = AW'(req_reg.position);
            end
            nwt_pkg::S_READ_WAIT:
            begin
                res_next.read_byte = in_range ? c : 8'h00;
            end
            nwt_pkg::S_NEXT:
            begin
                if (fin_reg)
                begin
                    res_next.status = nwt_pkg::STAT_END;
                end
            end
            nwt_pkg::S_SK_RD:
            begin
                ram_raddr = AW'(pos_reg);
                if (pos_reg >= len_reg)
                begin
                    res_next.status = nwt_pkg::STAT_END;
                    fin_next        = 1'b1;
                end
            end
            nwt_pkg::S_SK_EV:
            begin
                s_next     = pos_reg;
                rem_next   = len_reg - pos_reg;
                i_next     = '0;
                depth_next = '0;
                sp0_next   = nwt_pkg::spacey(c);
                split_next = 32'(lvl_reg) < 32'(cfg.max_literal_depth);
                if (c == nwt_pkg::CH_CLOSE)
                begin
                    if (lvl_reg != '0)
                    begin
                        lvl_next = lvl_reg - LEVEL_BITS'(1);
                        pos_next = pos_reg + LW'(1);
                    end
                    else
                    begin
                        res_next.status = nwt_pkg::STAT_CLOSE;
                        fin_next        = 1'b1;
                    end
                end
            end
            nwt_pkg::S_TR_RD:
            begin
                if (i_reg >= rem_reg)
                begin
                    res_next.status = nwt_pkg::STAT_UNCLOSED;
                    fin_next        = 1'b1;
                end
            end
            nwt_pkg::S_TR_EV:
            begin
                depth_next = dnew;
                if (dnew == '0)
                begin
                    res_next.status           = nwt_pkg::STAT_TOKEN;
                    res_next.token_level      = 4'(lvl_reg);
                    res_next.token_start      = 10'(s_reg);
                    res_next.token_length     = 11'(i_reg + LW'(1));
                    res_next.unescaped_length = 11'(i_reg + LW'(1));
                    if ((32'(lvl_reg) < 32'(cfg.max_tree_depth))
                        && (32'(lvl_reg) < LEVEL_MAX))
                    begin
                        lvl_next = lvl_reg + LEVEL_BITS'(1);
                        pos_next = s_reg + LW'(1);
                    end
                    else
                    begin
                        pos_next = s_reg + i_reg + LW'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + ((c == nwt_pkg::CH_ESCAPE) ? LW'(2) : LW'(1));
                end
            end
            nwt_pkg::S_LT_RD:
            begin
                if (i_reg >= rem_reg)
                begin
                    n_next   = (i_reg > rem_reg) ? rem_reg : i_reg;
                    i_next   = '0;
                    j_next   = '0;
                    esc_next = 1'b0;
                end
            end
            nwt_pkg::S_LT_EV:
            begin
                if (!sp0_reg && (c == nwt_pkg::CH_ESCAPE))
                begin
                    i_next = i_reg + LW'(2);
                end
                else if ((split_reg && (sp0_reg != nwt_pkg::spacey(c)))
                         || (c == nwt_pkg::CH_OPEN) || (c == nwt_pkg::CH_CLOSE))
                begin
                    n_next   = i_reg;
                    i_next   = '0;
                    j_next   = '0;
                    esc_next = 1'b0;
                end
                else
                begin
                    i_next = i_reg + LW'(1);
                end
            end
            nwt_pkg::S_CP_EV:
            begin
                if (!esc_reg && (c == nwt_pkg::CH_ESCAPE) && ((i_reg + LW'(1)) < n_reg))
                begin
                    i_next   = i_reg + LW'(1);
                    esc_next = 1'b1;
                end
                else
                begin
                    // Compacted bytes land at or behind the read point.
                    ram_we    = 1'b1;
                    ram_waddr = AW'(s_reg + j_reg);
                    ram_wdata = c;
                    i_next    = i_reg + LW'(1);
                    j_next    = j_reg + LW'(1);
                    esc_next  = 1'b0;
                    if ((i_reg + LW'(1)) >= n_reg)
                    begin
                        res_next.status           = nwt_pkg::STAT_TOKEN;
                        res_next.token_level      = 4'(lvl_reg);
                        res_next.token_start      = 10'(s_reg);
                        res_next.token_length     = 11'(n_reg);
                        res_next.unescaped_length = 11'(j_reg + LW'(1));
                        pos_next                  = s_reg + n_reg;
                    end
                end
            end
            nwt_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nwt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            pos_reg       <= '0;
            lvl_reg       <= '0;
            fin_reg       <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            lvl_reg       <= lvl_next;
            fin_reg       <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        n_reg     <= n_next;
        depth_reg <= depth_next;
        sp0_reg   <= sp0_next;
        split_reg <= split_next;
        esc_reg   <= esc_next;
    end

    `NWT_ASSERT_IMPL(a_compact_behind, clk, rst_n, ram_we && (state_reg == nwt_pkg::S_CP_EV), j_reg <= i_reg)
    `NWT_ASSERT_IMPL(a_pos_in_text, clk, rst_n, !fin_reg, pos_reg <= len_reg)
    `NWT_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit_go, out_valid_reg)

endmodule

`default_nettype wire

@@ design/nested_word_tree_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// nested_word_tree_tokenizer_top
// S-expression tokenizer with backslash escapes over a loaded text buffer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_ch     sink       mode, byte_in, position, text_length
//   out_ch    source     status, token_level, token_start, token_length,
//                        unescaped_length, read_byte
//   cfg_*     write      cfg_index selects the register, cfg_data the value
//
// A next-token request walks the buffer byte by byte (skipped closes and
// scanned bytes), and a literal's raw bytes are read once more for escape
// removal; the single read port of the text buffer, each byte read then
// evaluated, sets this pace. Reset clears the parse state and sets the
// limits to tree depth 1 and literal depth 0; the buffer itself is not
// cleared, so only written bytes may be read. A result beat that is not
// taken holds in the output register; the next request is still accepted
// and is worked on until its own result needs that register.
`default_nettype none

module nested_word_tree_tokenizer_top #(
    parameter int BUFFER_BYTES = nwt_pkg::BUFFER_BYTES_DEF,
    parameter int LEVEL_BITS   = nwt_pkg::LEVEL_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nwt_in_if.sink          in_ch,
    nwt_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    // Configuration registers; the user is to write them only while the block is idle; the block does not enforce it.
    nwt_pkg::nwt_cfg_t cfg_reg, cfg_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                nwt_pkg::CFG_MAX_TREE: cfg_next.max_tree_depth    = cfg_data;
                nwt_pkg::CFG_MAX_LIT:  cfg_next.max_literal_depth = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_tree_depth    <= 4'd1;
            cfg_reg.max_literal_depth <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The text buffer: bytes loaded by the user, rewritten in place when a
    // literal's escapes are removed.
    nwt_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request sequencer: one request at a time, walking the buffer.
    nwt_seq #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ tb/sv/nested_word_tree_tokenizer_top_test.sv @@
// ----------------------------------------------------------------------------
// nested_word_tree_tokenizer_top_test
// Self-checking bench for the s-expression tokenizer: loads texts, parses them
// token by token under changing depth limits, and checks every result beat
// against a predictor of its own.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: keeps a copy of the text buffer and the parse state, works out
// the result of every accepted request beat and compares result beats in order.
class token_scoreboard;
    localparam int unsigned DEPTH_CAP = 15;

    byte unsigned text[1024];
    int unsigned  parse_len;
    int unsigned  parse_pos;
    int unsigned  level;
    bit           finished;
    int unsigned  tree_limit;
    int unsigned  literal_limit;
    nwt_pkg::nwt_out_t pending[$];
    int           errors;
    int           status_seen[5];
    int           deepest;

    function new();
        parse_len = 0;
        parse_pos = 0;
        level = 0;
        finished = 1'b1;
        tree_limit = 1;
        literal_limit = 0;
        errors = 0;
        deepest = 0;
        foreach (text[i]) text[i] = 8'h00;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(logic index, logic [3:0] value);
        if (index == nwt_pkg::CFG_MAX_TREE) tree_limit = value;
        else literal_limit = value;
    endfunction

    function bit blank_byte(byte unsigned c);
        return c == nwt_pkg::CH_SPACE || c == nwt_pkg::CH_NEWLINE;
    endfunction

    // Notes one accepted request beat and returns the status it will report.
    function nwt_pkg::nwt_status_t note(nwt_pkg::nwt_in_t t);
        nwt_pkg::nwt_out_t r;
        int unsigned s, rem, n, i, j, d;
        bit sp0, split, hit;
        byte unsigned c;
        r = '0;
        r.status = nwt_pkg::STAT_ACCEPTED;
        case (t.mode)
            nwt_pkg::MODE_LOAD: text[t.position] = t.byte_in;
            nwt_pkg::MODE_BEGIN:
            begin
                parse_len = (t.text_length > 1024) ? 1024 : t.text_length;
                parse_pos = 0;
                level = 0;
                finished = 1'b0;
            end
            nwt_pkg::MODE_READ: r.read_byte = text[t.position];
            default:
            begin
                if (finished)
                begin
                    r.status = nwt_pkg::STAT_END;
                end
                else
                begin
                    // Closing parentheses first pop levels.
                    while (parse_pos < parse_len && text[parse_pos] == nwt_pkg::CH_CLOSE
                           && level > 0)
                    begin
                        level--;
                        parse_pos++;
                    end
                    s = parse_pos;
                    if (s >= parse_len)
                    begin
                        r.status = nwt_pkg::STAT_END;
                        finished = 1'b1;
                    end
                    else if (text[s] == nwt_pkg::CH_CLOSE)
                    begin
                        r.status = nwt_pkg::STAT_CLOSE;
                        finished = 1'b1;
                    end
                    else if (text[s] == nwt_pkg::CH_OPEN)
                    begin
                        rem = parse_len - s;
                        n = 0;
                        d = 0;
                        hit = 1'b0;
                        for (i = 0; i < rem && !hit; i++)
                        begin
                            c = text[s + i];
                            if (c == nwt_pkg::CH_OPEN) d++;
                            else if (c == nwt_pkg::CH_CLOSE) d--;
                            else if (c == nwt_pkg::CH_ESCAPE) i++;
                            if (d == 0)
                            begin
                                n = i + 1;
                                hit = 1'b1;
                            end
                        end
                        if (n == 0)
                        begin
                            r.status = nwt_pkg::STAT_UNCLOSED;
                            finished = 1'b1;
                        end
                        else
                        begin
                            r.status = nwt_pkg::STAT_TOKEN;
                            r.token_level = level;
                            r.token_start = s;
                            r.token_length = n;
                            r.unescaped_length = n;
                            if (level < tree_limit && level < DEPTH_CAP)
                            begin
                                level++;
                                parse_pos = s + 1;
                                if (level > deepest) deepest = level;
                            end
                            else
                            begin
                                parse_pos = s + n;
                            end
                        end
                    end
                    else
                    begin
                        rem = parse_len - s;
                        split = level < literal_limit;
                        sp0 = blank_byte(text[s]);
                        i = 0;
                        hit = 1'b0;
                        while (i < rem && !hit)
                        begin
                            c = text[s + i];
                            if (!sp0 && c == nwt_pkg::CH_ESCAPE)
                                i += 2;
                            else if ((split && sp0 != blank_byte(c)) ||
                                     c == nwt_pkg::CH_OPEN || c == nwt_pkg::CH_CLOSE)
                                hit = 1'b1;
                            else
                                i++;
                        end
                        n = (i > rem) ? rem : i;
                        // Escapes are removed in place; a lone trailing one stays.
                        i = 0;
                        j = 0;
                        while (i < n)
                        begin
                            c = text[s + i];
                            if (c == nwt_pkg::CH_ESCAPE && i + 1 < n)
                            begin
                                i++;
                                c = text[s + i];
                            end
                            text[s + j] = c;
                            i++;
                            j++;
                        end
                        r.status = nwt_pkg::STAT_TOKEN;
                        r.token_level = level;
                        r.token_start = s;
                        r.token_length = n;
                        r.unescaped_length = j;
                        parse_pos = s + n;
                    end
                end
            end
        endcase
        status_seen[r.status]++;
        pending.push_back(r);
        return nwt_pkg::nwt_status_t'(r.status);
    endfunction

    function void check(nwt_pkg::nwt_out_t got);
        nwt_pkg::nwt_out_t want;
        if (pending.size() == 0)
        begin
            $error("result beat with nothing expected: status %0d", got.status);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.token_level !== want.token_level)
        begin
            $error("token_level: expected %0d, got %0d", want.token_level, got.token_level);
            errors++;
        end
        if (got.token_start !== want.token_start)
        begin
            $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
            errors++;
        end
        if (got.token_length !== want.token_length)
        begin
            $error("token_length: expected %0d, got %0d",
                   want.token_length, got.token_length);
            errors++;
        end
        if (got.unescaped_length !== want.unescaped_length)
        begin
            $error("unescaped_length: expected %0d, got %0d",
                   want.unescaped_length, got.unescaped_length);
            errors++;
        end
        if (got.read_byte !== want.read_byte)
        begin
            $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
            errors++;
        end
    endfunction
endclass

module nested_word_tree_tokenizer_top_test;

    localparam int CYCLE_LIMIT = 20000000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;

    nwt_in_if  in_ch();
    nwt_out_if out_ch();

    nested_word_tree_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    token_scoreboard sb;

    // Buffer entries that have been written at least once. The block never
    // clears its buffer, so reads and parses stay inside written bytes.
    bit          written[1024];
    int          accepted;
    int          cycles;
    int          texts_run;
    bit          quiet;          // no random gaps on either side while set
    int          long_hold;      // cycles the receiver still holds off
    int          rx_stall;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: ready is driven at the falling edge. The long hold is counted
    // here, so the sender keeps offering beats while the block fills up.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                out_ch.ready = 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                out_ch.ready = 1'b0;
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Result beats are sampled at the rising edge; after each one the receiver
    // draws how long it waits before taking the next.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sb.check(out_ch.data);
            rx_stall = quiet ? 0 : $urandom_range(0, 7);
        end
    end

    function automatic nwt_pkg::nwt_in_t beat(nwt_pkg::nwt_mode_t m, logic [7:0] b,
                                              logic [9:0] pos, logic [10:0] len);
        nwt_pkg::nwt_in_t t;
        t.mode = m;
        t.byte_in = b;
        t.position = pos;
        t.text_length = len;
        return t;
    endfunction

    // Offers one request beat. Called at a falling edge and returns at one.
    // The gap lowers valid only when one is drawn, so valid stays high across
    // back-to-back beats.
    task automatic send(input nwt_pkg::nwt_in_t t, output nwt_pkg::nwt_status_t st);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.data = t;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        st = sb.note(t);
        if (t.mode == nwt_pkg::MODE_LOAD) written[t.position] = 1'b1;
        accepted++;
        @(negedge clk);
    endtask

    task automatic write_limit(input logic index, input logic [3:0] value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        sb.set_limit(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Lowers valid and waits until every expected beat has come back.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < 1024 && written[n]) n++;
        return n;
    endfunction

    function automatic logic [9:0] some_written_position();
        logic [9:0] p;
        p = $urandom_range(0, 1023);
        while (!written[p]) p = $urandom_range(0, 1023);
        return p;
    endfunction

    // Random text with the characters that matter made common. In balanced mode a
    // close only follows an open; open trees are closed at the end, up to 1024 bytes.
    function automatic void make_text(ref byte unsigned txt[$], input int len,
                                      input bit balanced);
        int depth, r;
        byte unsigned c;
        txt.delete();
        depth = 0;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15) c = nwt_pkg::CH_OPEN;
            else if (r < 30) c = nwt_pkg::CH_CLOSE;
            else if (r < 42) c = nwt_pkg::CH_SPACE;
            else if (r < 48) c = nwt_pkg::CH_NEWLINE;
            else if (r < 56) c = nwt_pkg::CH_ESCAPE;
            else if (r < 62) c = $urandom_range(0, 255);
            else c = $urandom_range(8'h61, 8'h7A);
            if (balanced && c == nwt_pkg::CH_CLOSE && depth == 0) c = 8'h78;
            if (c == nwt_pkg::CH_OPEN) depth++;
            if (c == nwt_pkg::CH_CLOSE) depth--;
            txt.push_back(c);
        end
        if (balanced)
            while (depth > 0 && txt.size() < 1024)
            begin
                txt.push_back(nwt_pkg::CH_CLOSE);
                depth--;
            end
    endfunction

    function automatic void text_of(ref byte unsigned txt[$], input string s);
        txt.delete();
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    // Requests tokens until the parse ends or the cap is reached, then once
    // more. Now and then a read of a written byte is mixed in.
    task automatic walk_tokens(input int cap = 300);
        nwt_pkg::nwt_status_t st;
        int n;
        n = 0;
        do
        begin
            if ($urandom_range(0, 9) == 0)
                send(beat(nwt_pkg::MODE_READ, $urandom, some_written_position(), $urandom),
                     st);
            send(beat(nwt_pkg::MODE_NEXT, $urandom, $urandom, $urandom), st);
            n++;
        end
        while (st == nwt_pkg::STAT_TOKEN && n < cap);
        send(beat(nwt_pkg::MODE_NEXT, $urandom, $urandom, $urandom), st);
    endtask

    // Loads a text at the start of the buffer, begins a parse over it and
    // walks its tokens. Some parses draw their length up to the written prefix.
    task automatic parse_text(ref byte unsigned txt[$]);
        nwt_pkg::nwt_status_t st;
        int len;
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send(beat(nwt_pkg::MODE_LOAD, $urandom, $urandom, $urandom), st);
            send(beat(nwt_pkg::MODE_LOAD, txt[i], i, $urandom), st);
        end
        len = txt.size();
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, written_prefix());
        send(beat(nwt_pkg::MODE_BEGIN, $urandom, $urandom, len), st);
        walk_tokens();
        texts_run++;
    endtask

    task automatic pick_limits();
        int r;
        r = $urandom_range(0, 3);
        write_limit(nwt_pkg::CFG_MAX_TREE,
                    (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : $urandom_range(0, 15));
        r = $urandom_range(0, 3);
        write_limit(nwt_pkg::CFG_MAX_LIT,
                    (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : $urandom_range(0, 15));
    endtask

    initial
    begin
        byte unsigned txt[$];
        nwt_pkg::nwt_status_t st;
        string nest;

        sb = new();
        accepted = 0;
        cycles = 0;
        texts_run = 0;
        quiet = 1'b0;
        long_hold = 0;
        rx_stall = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nwt_pkg::CFG_MAX_TREE;
        cfg_data = 4'd0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a token request before any parse, an empty parse, an
        // unexpected close, an unclosed tree, a tree cut by a lone backslash,
        // an escape at the very end of a literal, split and unsplit literals,
        // and nesting past the level cap with both limits at their maximum.
        send(beat(nwt_pkg::MODE_NEXT, 8'h00, 10'd0, 11'd0), st);
        text_of(txt, ")");
        parse_text(txt);
        send(beat(nwt_pkg::MODE_BEGIN, 8'hFF, 10'h3FF, 11'd0), st);
        send(beat(nwt_pkg::MODE_NEXT, 8'hFF, 10'h3FF, 11'h7FF), st);
        text_of(txt, "(a\\");
        parse_text(txt);
        text_of(txt, "a\\ b\\");
        parse_text(txt);
        drain();
        write_limit(nwt_pkg::CFG_MAX_LIT, 4'd15);
        text_of(txt, "ab  c\n(d)");
        parse_text(txt);
        drain();
        write_limit(nwt_pkg::CFG_MAX_TREE, 4'd15);
        nest = "";
        for (int i = 0; i < 17; i++) nest = {"(", nest, ")"};
        text_of(txt, nest);
        parse_text(txt);

        // Random texts, mostly balanced so that parses run deep. Limits change
        // only once every expected beat is back.
        while (accepted < 200)
        begin
            drain();
            if ($urandom_range(0, 2) == 0) pick_limits();
            quiet = ($urandom_range(0, 4) == 0);
            if (texts_run == 12)
            begin
                // The receiver stops for a long stretch while beats keep coming.
                quiet = 1'b1;
                long_hold = 400;
            end
            if ($urandom_range(0, 9) == 0) make_text(txt, $urandom_range(30, 120), 1'b1);
            else make_text(txt, $urandom_range(1, 24), $urandom_range(0, 3) != 0);
            parse_text(txt);
        end

        // Fill the whole buffer, then parse with lengths at and past its size.
        drain();
        quiet = 1'b1;
        make_text(txt, 1000, 1'b1);
        while (txt.size() < 1024) txt.push_back($urandom_range(0, 255));
        for (int i = 0; i < 1024; i++)
        begin
            if (i[2:0] == 3'd0) quiet = ($urandom_range(0, 3) == 0);
            send(beat(nwt_pkg::MODE_LOAD, txt[i], i, $urandom), st);
        end
        for (int k = 0; k < 2; k++)
        begin
            drain();
            pick_limits();
            send(beat(nwt_pkg::MODE_BEGIN, $urandom, $urandom,
                      (k == 0) ? 11'd1024 : 11'h7FF),
                 st);
            walk_tokens(60);
        end
        for (int k = 0; k < 40; k++)
            send(beat(nwt_pkg::MODE_READ, $urandom, $urandom_range(0, 1023), $urandom), st);

        drain();
        repeat (50) @(negedge clk);
        $display("Covered %0d request beats over %0d texts; statuses seen:", accepted,
                 texts_run);
        $display("  token %0d, end %0d, close %0d, unclosed %0d; deepest level %0d.",
                 sb.status_seen[nwt_pkg::STAT_TOKEN], sb.status_seen[nwt_pkg::STAT_END],
                 sb.status_seen[nwt_pkg::STAT_CLOSE], sb.status_seen[nwt_pkg::STAT_UNCLOSED],
                 sb.deepest);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
